FILE: rtl/cbsd_pkg.sv
// ----------------------------------------------------------------------------
// cbsd_pkg
// Shared types and constants for the color blob steering decider.
// ----------------------------------------------------------------------------
package cbsd_pkg;

    // Datapath sizing
    localparam int COLUMN_BITS = 12;
    localparam int COUNT_BITS  = 24;
    localparam int SUM_BITS    = COUNT_BITS + COLUMN_BITS;

    // Fixed field widths
    localparam int COLOR_BITS  = 24;
    localparam int WIDTH_BITS  = 13;
    localparam int SPEED_BITS  = 15;
    localparam int ANG_BITS    = 16;
    localparam int COLUMN_IN_BITS = 12;
    localparam int S_DATA_BITS = 40;
    localparam int M_DATA_BITS = 40;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 24;

    // Compare width: holds 3*sum and 2*width*count
    localparam int SCALED_BITS = SUM_BITS + 2;
    localparam int PROD2_BITS  = WIDTH_BITS + COUNT_BITS + 1;
    localparam int CMP_BITS    = (SCALED_BITS > PROD2_BITS) ? SCALED_BITS : PROD2_BITS;

    // Steering direction codes
    typedef enum logic [1:0] {
        DIR_STOP     = 2'd0,
        DIR_LEFT     = 2'd1,
        DIR_RIGHT    = 2'd2,
        DIR_STRAIGHT = 2'd3
    } dir_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_TARGET_COLOR  = 2'd0,
        REG_FRAME_WIDTH   = 2'd1,
        REG_FORWARD_SPEED = 2'd2,
        REG_TURN_SPEED    = 2'd3
    } reg_idx_t;

    // Reset values
    localparam logic [COLOR_BITS-1:0] TARGET_RESET = 24'hFF_FFFF;
    localparam logic [WIDTH_BITS-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [SPEED_BITS-1:0] SPEED_RESET  = 15'd128;

    // Live configuration
    typedef struct packed {
        logic [COLOR_BITS-1:0] target_color;
        logic [WIDTH_BITS-1:0] frame_width;
        logic [SPEED_BITS-1:0] forward_speed;
        logic [SPEED_BITS-1:0] turn_speed;
    } cfg_t;

    // Per-frame totals handed to the decision stage
    typedef struct packed {
        logic [COUNT_BITS-1:0] match_count;
        logic [SUM_BITS-1:0]   column_sum;
    } snap_t;

endpackage

FILE: rtl/color_blob_steering_decider.sv
// ----------------------------------------------------------------------------
// color_blob_steering_decider
// Path: the end-of-frame pixel passes the input reg, accumulate/snapshot,
//   product and command reg in order; a command issues only on a direction change.
// Throughput: one pixel per clock, with the match and add combinational; an
//   end-of-frame pixel waits only while a command word is held by m_tready.
// Reset: async active low; drive state stop, accumulators zero, registers at
//   their defaults (white target, width 640, both speeds 128).
// ----------------------------------------------------------------------------
module color_blob_steering_decider (
    input  logic                                clk,
    input  logic                                rst_n,
    // Pixel stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata: red[7:0], green[15:8], blue[23:16], column[35:24], zero pad
    input  logic [cbsd_pkg::S_DATA_BITS-1:0]    s_tdata,
    input  logic                                s_tlast,   // end_of_frame
    // Drive commands
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata: direction[1:0], linear_speed[16:2], angular_speed[32:17], zero pad
    output logic [cbsd_pkg::M_DATA_BITS-1:0]    m_tdata,
    // Configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cbsd_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [cbsd_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import cbsd_pkg::*;

    cfg_t                  cfg;
    snap_t                 snap;
    logic                  snap_valid;
    logic                  snap_ready;
    logic [1:0]            cmd_direction;
    logic [SPEED_BITS-1:0] cmd_linear;
    logic [ANG_BITS-1:0]   cmd_angular;
    logic [COLOR_BITS-1:0] pix_color;

    // Pack pixel as red in the top byte, matching the target layout
    assign pix_color = {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]};

    cbsd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cbsd_accum u_accum (
        .clk          (clk),
        .rst_n        (rst_n),
        .pix_valid    (s_tvalid),
        .pix_ready    (s_tready),
        .pix_color    (pix_color),
        .pix_column   (s_tdata[35:24]),
        .pix_eof      (s_tlast),
        .target_color (cfg.target_color),
        .snap_valid   (snap_valid),
        .snap_ready   (snap_ready),
        .snap         (snap)
    );

    cbsd_decide u_decide (
        .clk           (clk),
        .rst_n         (rst_n),
        .snap_valid    (snap_valid),
        .snap_ready    (snap_ready),
        .snap          (snap),
        .cfg           (cfg),
        .cmd_valid     (m_tvalid),
        .cmd_ready     (m_tready),
        .cmd_direction (cmd_direction),
        .cmd_linear    (cmd_linear),
        .cmd_angular   (cmd_angular)
    );

    assign m_tdata = {7'd0, cmd_angular, cmd_linear, cmd_direction};

endmodule

FILE: rtl/cbsd_cfg.sv
// ----------------------------------------------------------------------------
// cbsd_cfg
// Configuration register file; indexes past the list are ignored.
// ----------------------------------------------------------------------------
module cbsd_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [cbsd_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [cbsd_pkg::CFG_DATA_BITS-1:0] cfg_data,
    output cbsd_pkg::cfg_t                     cfg
);
    import cbsd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    // Register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_TARGET_COLOR:  cfg_next.target_color  = cfg_data[COLOR_BITS-1:0];
                REG_FRAME_WIDTH:   cfg_next.frame_width   = cfg_data[WIDTH_BITS-1:0];
                REG_FORWARD_SPEED: cfg_next.forward_speed = cfg_data[SPEED_BITS-1:0];
                REG_TURN_SPEED:    cfg_next.turn_speed    = cfg_data[SPEED_BITS-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_color  <= TARGET_RESET;
            cfg_reg.frame_width   <= WIDTH_RESET;
            cfg_reg.forward_speed <= SPEED_RESET;
            cfg_reg.turn_speed    <= SPEED_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: rtl/cbsd_accum.sv
// ----------------------------------------------------------------------------
// cbsd_accum
// Pixel input register, color match and saturating count/sum accumulators.
// On the end-of-frame pixel the totals move to a snapshot register.
// ----------------------------------------------------------------------------
module cbsd_accum (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                pix_valid,
    output logic                                pix_ready,
    input  logic [cbsd_pkg::COLOR_BITS-1:0]     pix_color,
    input  logic [cbsd_pkg::COLUMN_IN_BITS-1:0] pix_column,
    input  logic                                pix_eof,
    input  logic [cbsd_pkg::COLOR_BITS-1:0]     target_color,
    output logic                                snap_valid,
    input  logic                                snap_ready,
    output cbsd_pkg::snap_t                     snap
);
    import cbsd_pkg::*;

    // Input register
    logic                    in_valid_reg, in_valid_next;
    logic [COLOR_BITS-1:0]   color_reg;
    logic [COLUMN_BITS-1:0]  column_reg;
    logic                    eof_reg;

    // Accumulators and snapshot
    logic [COUNT_BITS-1:0]   count_reg, count_next;
    logic [SUM_BITS-1:0]     sum_reg, sum_next;
    logic                    snap_valid_reg, snap_valid_next;
    snap_t                   snap_reg;

    logic                    in_go;
    logic                    match;
    logic [COUNT_BITS-1:0]   count_upd;
    logic [SUM_BITS:0]       sum_wide;
    logic [SUM_BITS-1:0]     sum_upd;
    logic                    snap_room;

    assign snap_room = !snap_valid_reg || snap_ready;
    assign in_go     = in_valid_reg && (!eof_reg || snap_room);
    assign pix_ready = !in_valid_reg || in_go;

    // Match and saturating update
    assign match    = (color_reg == target_color);
    assign sum_wide = {1'b0, sum_reg} + (SUM_BITS+1)'(column_reg);

    always_comb
    begin
        count_upd = count_reg;
        sum_upd   = sum_reg;
        if (match)
        begin
            if (count_reg != {COUNT_BITS{1'b1}})
                count_upd = count_reg + COUNT_BITS'(1);
            sum_upd = sum_wide[SUM_BITS] ? {SUM_BITS{1'b1}} : sum_wide[SUM_BITS-1:0];
        end
    end

    // Next state of accumulators and snapshot handshake
    always_comb
    begin
        count_next      = count_reg;
        sum_next        = sum_reg;
        snap_valid_next = snap_valid_reg && !snap_ready;
        in_valid_next   = in_valid_reg && !in_go;
        if (in_go)
        begin
            if (eof_reg)
            begin
                count_next      = '0;
                sum_next        = '0;
                snap_valid_next = 1'b1;
            end
            else
            begin
                count_next = count_upd;
                sum_next   = sum_upd;
            end
        end
        if (pix_valid && pix_ready)
            in_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            count_reg      <= '0;
            sum_reg        <= '0;
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg   <= in_valid_next;
            count_reg      <= count_next;
            sum_reg        <= sum_next;
            snap_valid_reg <= snap_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (pix_valid && pix_ready)
        begin
            color_reg  <= pix_color;
            column_reg <= COLUMN_BITS'(pix_column);
            eof_reg    <= pix_eof;
        end
        if (in_go && eof_reg)
        begin
            snap_reg.match_count <= count_upd;
            snap_reg.column_sum  <= sum_upd;
        end
    end

    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;

    // Frame end clears the accumulators
    a_clear_on_eof: assert property (@(posedge clk) disable iff (!rst_n)
        (in_go && eof_reg) |=> (count_reg == '0 && sum_reg == '0))
        else $error("accumulators not cleared after frame end");

    // No matches means no column sum
    a_zero_count_zero_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (snap_valid_reg && snap_reg.match_count == '0) |-> (snap_reg.column_sum == '0))
        else $error("snapshot sum nonzero with zero count");

endmodule

FILE: rtl/cbsd_decide.sv
// ----------------------------------------------------------------------------
// cbsd_decide
// Product stage (width*count, 3*sum), direction choice against drive state,
// and the command output register.
// ----------------------------------------------------------------------------
module cbsd_decide (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               snap_valid,
    output logic                               snap_ready,
    input  cbsd_pkg::snap_t                    snap,
    input  cbsd_pkg::cfg_t                     cfg,
    output logic                               cmd_valid,
    input  logic                               cmd_ready,
    output logic [1:0]                         cmd_direction,
    output logic [cbsd_pkg::SPEED_BITS-1:0]    cmd_linear,
    output logic [cbsd_pkg::ANG_BITS-1:0]      cmd_angular
);
    import cbsd_pkg::*;

    // Product stage
    logic                 prod_valid_reg, prod_valid_next;
    logic [CMP_BITS-1:0]  scaled_reg;
    logic [CMP_BITS-1:0]  third_reg;
    logic                 empty_reg;

    // Drive state and output register
    dir_t                 drive_state_reg, drive_state_next;
    logic                 out_valid_reg, out_valid_next;
    dir_t                 dir_reg;
    logic [SPEED_BITS-1:0] lin_reg;
    logic [ANG_BITS-1:0]  ang_reg;

    logic [CMP_BITS-1:0]  scaled_c;
    logic [CMP_BITS-1:0]  twice;
    dir_t                 pick;
    logic                 change;
    logic                 out_free;
    logic                 prod_go;
    logic                 prod_ready;

    // 3*sum as shift and add
    assign scaled_c = (CMP_BITS'(snap.column_sum) << 1) + CMP_BITS'(snap.column_sum);

    // Direction from the registered products
    assign twice = third_reg << 1;
    always_comb
    begin
        if (empty_reg)
            pick = DIR_STOP;
        else if (scaled_reg < third_reg)
            pick = DIR_LEFT;
        else if (scaled_reg > twice)
            pick = DIR_RIGHT;
        else
            pick = DIR_STRAIGHT;
    end

    assign change     = (pick != drive_state_reg);
    assign out_free   = !out_valid_reg || cmd_ready;
    assign prod_go    = prod_valid_reg && (!change || out_free);
    assign prod_ready = !prod_valid_reg || prod_go;
    assign snap_ready = prod_ready;

    always_comb
    begin
        prod_valid_next  = prod_valid_reg && !prod_go;
        drive_state_next = drive_state_reg;
        out_valid_next   = out_valid_reg && !cmd_ready;
        if (snap_valid && prod_ready)
            prod_valid_next = 1'b1;
        if (prod_go && change)
        begin
            drive_state_next = pick;
            out_valid_next   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg  <= 1'b0;
            drive_state_reg <= DIR_STOP;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            prod_valid_reg  <= prod_valid_next;
            drive_state_reg <= drive_state_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (snap_valid && prod_ready)
        begin
            scaled_reg <= scaled_c;
            third_reg  <= CMP_BITS'(cfg.frame_width) * CMP_BITS'(snap.match_count);
            empty_reg  <= (snap.match_count == '0);
        end
        if (prod_go && change)
        begin
            dir_reg <= pick;
            lin_reg <= (pick == DIR_STRAIGHT) ? cfg.forward_speed : '0;
            case (pick)
                DIR_LEFT:  ang_reg <= ANG_BITS'(cfg.turn_speed);
                DIR_RIGHT: ang_reg <= ANG_BITS'(0) - ANG_BITS'(cfg.turn_speed);
                default:   ang_reg <= '0;
            endcase
        end
    end

    assign cmd_valid     = out_valid_reg;
    assign cmd_direction = dir_reg;
    assign cmd_linear    = lin_reg;
    assign cmd_angular   = ang_reg;

    // Pending command always reflects the current drive state
    a_cmd_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (dir_reg == drive_state_reg))
        else $error("pending command differs from drive state");

    // Linear speed only when driving straight
    a_linear_only_straight: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && dir_reg != DIR_STRAIGHT) |-> (lin_reg == '0))
        else $error("linear speed set while not straight");

endmodule
